// ----- rtl/qtu_pkg.sv -----
// Shared types, constants and character helpers of the quoted token unescaper.
package qtu_pkg;

   localparam int TOKEN_LEN_MAX = 4095;
   localparam int LIMIT_W       = 12;
   localparam int POS_W         = 16;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]       CHR_QUOTE  = 8'h22;
   localparam logic [7:0]       CHR_BSLASH = 8'h5C;
   localparam logic [7:0]       CHR_HEX    = 8'h78;
   localparam logic [7:0]       CHR_NL     = 8'h0A;
   localparam logic [POS_W-1:0] POS_SAT    = '1;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_END     = 2'd1,
      KIND_HEX_ERR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      HEX_IDLE = 2'd0,
      HEX_HIGH = 2'd1,
      HEX_LOW  = 2'd2
   } hex_phase_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        out_byte;
      logic              truncated;
      logic [POS_W-1:0]  line_number;
      logic [POS_W-1:0]  column_number;
      logic              last_of_run;
   } result_type;

   // Results caused by one accepted byte, first one in r0
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } result_pair_type;

   typedef struct packed {
      logic               in_quotes;
      logic               escape_pending;
      hex_phase_type      hex_phase;
      logic [3:0]         hex_high_nibble;
      logic               token_open;
      logic [LIMIT_W-1:0] token_count;
      logic               overflowed;
      logic [POS_W-1:0]   line_count;
      logic [POS_W-1:0]   column_count;
   } dec_state_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = '0;
      if (c inside {[8'h30:8'h39]}) begin
         v = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         v = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         v = {1'b1, 4'(c - 8'h37)};
      end
      return v;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h61:   r = 8'd7;   // a
         8'h62:   r = 8'd8;   // b
         8'h65:   r = 8'd27;  // e
         8'h66:   r = 8'd12;  // f
         8'h6E:   r = 8'd10;  // n
         8'h72:   r = 8'd13;  // r
         8'h74:   r = 8'd9;   // t
         8'h76:   r = 8'd11;  // v
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/qtu_decoder.sv -----
// Per-byte tokenizer state and result generation.
module qtu_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire_i,
   input  logic [7:0]                     in_byte_i,
   input  logic                           end_of_input_i,
   input  logic [qtu_pkg::LIMIT_W-1:0]    limit_i,
   output qtu_pkg::result_pair_type       results_o
);
   import qtu_pkg::*;

   dec_state_type state_ff, state_in;
   result_pair_type pair;

   always_comb begin
      dec_state_type st;
      logic [4:0]    hv;
      logic          data_req;
      logic [7:0]    data_val;
      result_type    base, main_r, err_r, end_r;
      logic          main_vld, err_vld, end_vld;

      st       = state_ff;
      hv       = hex_value(in_byte_i);
      data_req = 1'b0;
      data_val = '0;
      main_vld = 1'b0;
      err_vld  = 1'b0;
      end_vld  = 1'b0;

      if (in_byte_i == CHR_NL || st.line_count == '0) begin
         if (st.line_count != POS_SAT) st.line_count = st.line_count + 1'b1;
         st.column_count = '0;
      end else if (st.column_count != POS_SAT) begin
         st.column_count = st.column_count + 1'b1;
      end

      base               = '0;
      base.kind          = KIND_DATA;
      base.line_number   = st.line_count;
      base.column_number = st.column_count;
      main_r             = base;
      err_r              = base;
      err_r.kind         = KIND_HEX_ERR;
      end_r              = base;
      end_r.kind         = KIND_END;

      if (st.escape_pending) begin
         st.escape_pending = 1'b0;
         if (in_byte_i == CHR_HEX) begin
            st.hex_phase = HEX_HIGH;
         end else begin
            data_req = 1'b1;
            data_val = escape_map(in_byte_i);
         end
      end else if (st.hex_phase != HEX_IDLE) begin
         if (!hv[4]) begin
            st.hex_phase = HEX_IDLE;
            main_vld     = 1'b1;
            main_r.kind  = KIND_HEX_ERR;
         end else if (st.hex_phase == HEX_HIGH) begin
            st.hex_high_nibble = hv[3:0];
            st.hex_phase       = HEX_LOW;
         end else begin
            st.hex_phase = HEX_IDLE;
            data_req     = 1'b1;
            data_val     = {st.hex_high_nibble, hv[3:0]};
         end
      end else if (in_byte_i == CHR_QUOTE) begin
         st.in_quotes  = ~st.in_quotes;
         st.token_open = 1'b1;
      end else if (in_byte_i == CHR_BSLASH) begin
         st.escape_pending = 1'b1;
         st.token_open     = 1'b1;
      end else if (!st.in_quotes && is_separator(in_byte_i)) begin
         if (st.token_open) begin
            main_vld         = 1'b1;
            main_r.kind      = KIND_END;
            main_r.truncated = st.overflowed;
            st.token_open    = 1'b0;
            st.token_count   = '0;
            st.overflowed    = 1'b0;
         end
      end else begin
         data_req = 1'b1;
         data_val = in_byte_i;
      end

      if (data_req) begin
         st.token_open = 1'b1;
         if (st.token_count < limit_i) begin
            st.token_count  = st.token_count + 1'b1;
            main_vld        = 1'b1;
            main_r.out_byte = data_val;
         end else begin
            st.overflowed = 1'b1;
         end
      end

      if (end_of_input_i) begin
         err_vld         = (st.hex_phase != HEX_IDLE);
         end_vld         = st.token_open;
         end_r.truncated = st.overflowed;
         st              = '0;
      end

      // at most two of the three can be set
      pair = '0;
      if (main_vld) begin
         pair.r0 = main_r;
         pair.r1 = err_vld ? err_r : end_r;
      end else if (err_vld) begin
         pair.r0 = err_r;
         pair.r1 = end_r;
      end else begin
         pair.r0 = end_r;
      end
      pair.count = 2'(main_vld) + 2'(err_vld) + 2'(end_vld);
      pair.r0.last_of_run = (pair.count == 2'd1);
      pair.r1.last_of_run = 1'b1;

      state_in = fire_i ? st : state_ff;
   end

   assign results_o = fire_i ? pair : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/qtu_result_queue.sv -----
// Small result queue: takes up to two results a cycle, delivers one while ready_i is high.
module qtu_result_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  qtu_pkg::result_pair_type  results_i,
   output logic                      space_o,
   output logic                      valid_o,
   input  logic                      ready_i,
   output qtu_pkg::result_type       head_o
);
   import qtu_pkg::*;

   result_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               pop;
   logic [QPTR_W-1:0]  wr_next;

   assign valid_o = (fill_ff != '0);
   assign head_o  = slot_ff[rd_ptr_ff];
   // room for a full pair regardless of this cycle's drain
   assign space_o = (fill_ff <= QFILL_W'(QUEUE_DEPTH - 2));
   assign pop     = valid_o && ready_i;
   assign wr_next = wr_ptr_ff + 1'b1;

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(results_i.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign fill_in   = fill_ff + QFILL_W'(results_i.count) - QFILL_W'(pop);

   always_ff @(posedge clock) begin
      if (results_i.count != 2'd0) slot_ff[wr_ptr_ff] <= results_i.r0;
      if (results_i.count == 2'd2) slot_ff[wr_next] <= results_i.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- rtl/quoted_token_unescaper.sv -----
// Top level: splits a byte stream into tokens and decodes C-style escapes.
//
// One byte is taken per cycle and decoded in the same cycle into zero, one or two
// results (data byte, token end, bad hex escape), which enter a four-entry result
// queue; the result port delivers one per ready cycle. req_tready is high while the queue
// holds two results or fewer, so the block sustains one byte per cycle as long as the
// output drains one result per cycle; a byte that closes a token at end of input
// with a preceding result yields two results in one transfer. Token length limit is
// min(csr_data, MAX_TOKEN, 4095); writes are taken at any time with csr_ready high.
module quoted_token_unescaper #(
   parameter int MAX_TOKEN = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_byte, [8] truncated,
                                    // [24:9] line_number, [40:25] column_number
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data     // max_token_len
);
   import qtu_pkg::*;

   localparam int               CAP_I     = (MAX_TOKEN > TOKEN_LEN_MAX) ? TOKEN_LEN_MAX
                                                                      : MAX_TOKEN;
   localparam logic [LIMIT_W-1:0] CAP       = LIMIT_W'(CAP_I);
   localparam logic [LIMIT_W-1:0] LIMIT_RST = (CAP_I < 255) ? CAP : LIMIT_W'(255);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               req_fire;
   result_pair_type    results;
   result_type         head;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? ((csr_data < CAP) ? csr_data : CAP)
                                               : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RST;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign req_fire = req_tvalid && req_tready;

   qtu_decoder u_decoder (
      .clock          (clock),
      .reset          (reset),
      .fire_i         (req_fire),
      .in_byte_i      (req_tdata),
      .end_of_input_i (req_tlast),
      .limit_i        (limit_ff),
      .results_o      (results)
   );

   qtu_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .results_i (results),
      .space_o   (req_tready),
      .valid_o   (rsp_tvalid),
      .ready_i   (rsp_tready),
      .head_o    (head)
   );

   assign rsp_tdata = {7'd0, head.column_number, head.line_number, head.truncated,
                       head.out_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_run;

   // only the final result of a transfer carries last_of_run
   assert property (@(posedge clock) disable iff (reset)
      results.count == 2'd2 |-> results.r1.last_of_run && !results.r0.last_of_run)
      else $error("last_of_run misplaced in result pair");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_END |-> !rsp_tdata[8])
      else $error("truncated set on a result that is not a token end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DATA |-> rsp_tdata[7:0] == 8'd0)
      else $error("nonzero byte on a non-data result");

   // the decoder stays silent on cycles without an input transfer
   assert property (@(posedge clock) disable iff (reset)
      !req_fire |-> results.count == 2'd0)
      else $error("results produced without an input transfer");

endmodule
